[design/mcd_pkg.sv]
// mcd_pkg: shared types and constants for the moesi coherence directory
// holds state codes, field widths, controller states and control structs
// no dependencies
package mcd_pkg;

    // fixed field widths of the request and result ports
    localparam int ACTION_W    = 1;
    localparam int CACHE_IDX_W = 2;
    localparam int LINE_IDX_W  = 2;
    localparam int STATE_W     = 3;
    localparam int MASK_W      = 3;

    // moesi state codes
    localparam logic [STATE_W-1:0] ST_M = 3'd0;
    localparam logic [STATE_W-1:0] ST_O = 3'd1;
    localparam logic [STATE_W-1:0] ST_E = 3'd2;
    localparam logic [STATE_W-1:0] ST_S = 3'd3;
    localparam logic [STATE_W-1:0] ST_I = 3'd4;

    // processor access codes
    localparam logic [ACTION_W-1:0] ACT_READ  = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_LOOKUP
    } t_ctrl_state;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
    } t_dp_status;

endpackage

[design/moesi_coherence_directory.sv]
// Coherence directory holding one MOESI state for every line of every cache. For each request
// (a processor read or write by one cache to one line) the line's row of states is first read
// from a registered-output memory; then all peer states are updated in parallel and written
// back while the result is registered. No new request is taken until the previous one has been
// committed; a waiting result stalls the block only when a second result is ready. After reset
// a clearing pass sets every entry Invalid, one row a cycle, during which no request is accepted.
// top level: instantiates mcd_ctrl and mcd_datapath, depends on mcd_pkg
module moesi_coherence_directory #(
    parameter int NUM_CACHES = 3,
    parameter int NUM_LINES  = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [mcd_pkg::ACTION_W-1:0]       i_action,
    input  logic [mcd_pkg::CACHE_IDX_W-1:0]    i_cache_index,
    input  logic [mcd_pkg::LINE_IDX_W-1:0]     i_line_index,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_was_hit,
    output logic [mcd_pkg::STATE_W-1:0]        o_new_state,
    output logic                               o_peer_had_copy,
    output logic                               o_dirty_supply,
    output logic                               o_memory_read,
    output logic [mcd_pkg::MASK_W-1:0]         o_invalidated_mask
);

    mcd_pkg::t_dp_cmd    w_cmd;
    mcd_pkg::t_dp_status w_status;

    // controller
    mcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // datapath
    mcd_datapath #(
        .NUM_CACHES (NUM_CACHES),
        .NUM_LINES  (NUM_LINES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_action           (i_action),
        .i_cache_index      (i_cache_index),
        .i_line_index       (i_line_index),
        .o_was_hit          (o_was_hit),
        .o_new_state        (o_new_state),
        .o_peer_had_copy    (o_peer_had_copy),
        .o_dirty_supply     (o_dirty_supply),
        .o_memory_read      (o_memory_read),
        .o_invalidated_mask (o_invalidated_mask)
    );

endmodule

[design/mcd_datapath.sv]
// mcd_datapath: state memory, request capture, coherence update and result registers
// one memory row per line holds the states of all caches for that line
// depends on mcd_pkg
module mcd_datapath #(
    parameter int NUM_CACHES = 3,
    parameter int NUM_LINES  = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mcd_pkg::t_dp_cmd                   i_cmd,
    output mcd_pkg::t_dp_status                o_status,
    input  logic [mcd_pkg::ACTION_W-1:0]       i_action,
    input  logic [mcd_pkg::CACHE_IDX_W-1:0]    i_cache_index,
    input  logic [mcd_pkg::LINE_IDX_W-1:0]     i_line_index,
    output logic                               o_was_hit,
    output logic [mcd_pkg::STATE_W-1:0]        o_new_state,
    output logic                               o_peer_had_copy,
    output logic                               o_dirty_supply,
    output logic                               o_memory_read,
    output logic [mcd_pkg::MASK_W-1:0]         o_invalidated_mask
);

    localparam int LINE_AW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int ROW_W   = NUM_CACHES * mcd_pkg::STATE_W;

    // state memory, one row per line
    logic [ROW_W-1:0] r_mem [NUM_LINES];
    logic [ROW_W-1:0] r_rd_data;

    // captured request
    logic [mcd_pkg::ACTION_W-1:0]    r_action;
    logic [mcd_pkg::CACHE_IDX_W-1:0] r_cache;
    logic [LINE_AW-1:0]              r_addr;
    logic                            r_in_range;

    // clearing pass counter
    logic [LINE_AW-1:0] r_clr_addr;

    // result registers
    logic                          r_was_hit;
    logic [mcd_pkg::STATE_W-1:0]   r_new_state;
    logic                          r_peer_had;
    logic                          r_dirty;
    logic                          r_mem_read;
    logic [mcd_pkg::MASK_W-1:0]    r_mask;

    // update logic results
    logic [ROW_W-1:0]              w_new_row;
    logic                          w_hit;
    logic [mcd_pkg::STATE_W-1:0]   w_state;
    logic                          w_peer_any;
    logic                          w_dirty;
    logic                          w_mem_read;
    logic [mcd_pkg::MASK_W-1:0]    w_mask;
    logic                          w_in_range;

    logic                          w_wr_en;
    logic [LINE_AW-1:0]            w_wr_addr;
    logic [ROW_W-1:0]              w_wr_data;

    // range check of the incoming request
    assign w_in_range = (32'(i_cache_index) < NUM_CACHES) && (32'(i_line_index) < NUM_LINES);

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action   <= i_action;
            r_cache    <= i_cache_index;
            r_addr     <= LINE_AW'(i_line_index);
            r_in_range <= w_in_range;
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + LINE_AW'(1);
        end
    end

    assign o_status.clear_done = (32'(r_clr_addr) == NUM_LINES - 1);

    // memory write port: clearing pass or write-back of the updated row
    assign w_wr_en   = i_cmd.clear || (i_cmd.commit && r_in_range);
    assign w_wr_addr = i_cmd.clear ? r_clr_addr : r_addr;
    assign w_wr_data = i_cmd.clear ? {NUM_CACHES{mcd_pkg::ST_I}} : w_new_row;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[LINE_AW'(i_line_index)];
        end
    end

    // coherence update of one line across all caches
    always_comb begin
        logic [mcd_pkg::STATE_W-1:0] own;
        logic [mcd_pkg::STATE_W-1:0] s;
        logic                        s_valid;
        logic                        s_dirty;
        own        = mcd_pkg::ST_I;
        w_new_row  = r_rd_data;
        w_peer_any = 1'b0;
        w_dirty    = 1'b0;
        w_mask     = '0;
        w_mem_read = 1'b0;
        w_state    = mcd_pkg::ST_I;

        // requester's own state
        for (int i = 0; i < NUM_CACHES; i++) begin
            if (i == int'(r_cache)) begin
                own = r_rd_data[i*mcd_pkg::STATE_W +: mcd_pkg::STATE_W];
            end
        end
        w_hit = (own != mcd_pkg::ST_I);

        // snoop of every peer
        for (int i = 0; i < NUM_CACHES; i++) begin
            s       = r_rd_data[i*mcd_pkg::STATE_W +: mcd_pkg::STATE_W];
            s_valid = (s != mcd_pkg::ST_I);
            s_dirty = (s == mcd_pkg::ST_M) || (s == mcd_pkg::ST_O);
            if (i != int'(r_cache)) begin
                if (s_valid) begin
                    w_peer_any = 1'b1;
                end
                if (r_action == mcd_pkg::ACT_WRITE) begin
                    // write: flush dirty peers, invalidate every valid peer
                    if (s_valid) begin
                        if (s_dirty) begin
                            w_dirty = 1'b1;
                        end
                        w_new_row[i*mcd_pkg::STATE_W +: mcd_pkg::STATE_W] = mcd_pkg::ST_I;
                        if (i < mcd_pkg::MASK_W) begin
                            w_mask[i] = 1'b1;
                        end
                    end
                end else if (!w_hit) begin
                    // read miss: dirty peer supplies, M to O, E to S
                    if (s_dirty) begin
                        w_dirty = 1'b1;
                    end
                    if (s == mcd_pkg::ST_M) begin
                        w_new_row[i*mcd_pkg::STATE_W +: mcd_pkg::STATE_W] = mcd_pkg::ST_O;
                    end else if (s == mcd_pkg::ST_E) begin
                        w_new_row[i*mcd_pkg::STATE_W +: mcd_pkg::STATE_W] = mcd_pkg::ST_S;
                    end
                end
            end
        end

        // requester's new state
        if (r_action == mcd_pkg::ACT_WRITE) begin
            w_state    = mcd_pkg::ST_M;
            w_mem_read = !w_hit && !w_peer_any;
        end else if (w_hit) begin
            w_state = own;
        end else begin
            w_state    = w_peer_any ? mcd_pkg::ST_S : mcd_pkg::ST_E;
            w_mem_read = !w_peer_any;
        end

        for (int i = 0; i < NUM_CACHES; i++) begin
            if (i == int'(r_cache)) begin
                w_new_row[i*mcd_pkg::STATE_W +: mcd_pkg::STATE_W] = w_state;
            end
        end
    end

    // result registers, idle result for an out-of-range request
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_in_range) begin
                r_was_hit   <= w_hit;
                r_new_state <= w_state;
                r_peer_had  <= w_peer_any;
                r_dirty     <= w_dirty;
                r_mem_read  <= w_mem_read;
                r_mask      <= w_mask;
            end else begin
                r_was_hit   <= 1'b0;
                r_new_state <= mcd_pkg::ST_I;
                r_peer_had  <= 1'b0;
                r_dirty     <= 1'b0;
                r_mem_read  <= 1'b0;
                r_mask      <= '0;
            end
        end
    end

    assign o_was_hit          = r_was_hit;
    assign o_new_state        = r_new_state;
    assign o_peer_had_copy    = r_peer_had;
    assign o_dirty_supply     = r_dirty;
    assign o_memory_read      = r_mem_read;
    assign o_invalidated_mask = r_mask;

endmodule

[design/mcd_ctrl.sv]
// mcd_ctrl: controller state machine for the moesi coherence directory
// sequences the clearing pass, request capture, write-back and result handshake
// depends on mcd_pkg
module mcd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  mcd_pkg::t_dp_status i_status,
    output mcd_pkg::t_dp_cmd    o_cmd
);

    mcd_pkg::t_ctrl_state r_state;
    mcd_pkg::t_ctrl_state n_state;
    logic                 r_out_valid;
    logic                 n_out_valid;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcd_pkg::CS_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_stall    = 1'b1;
        unique case (r_state)
            mcd_pkg::CS_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) begin
                    n_state = mcd_pkg::CS_IDLE;
                end
            end
            mcd_pkg::CS_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = mcd_pkg::CS_LOOKUP;
                end
            end
            mcd_pkg::CS_LOOKUP: begin
                // commit once the result register is free or being drained
                if (!r_out_valid || !i_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = mcd_pkg::CS_IDLE;
                end
            end
            default: begin
                n_state = mcd_pkg::CS_CLEAR;
            end
        endcase
    end

    // result valid
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    // a waiting result is never dropped
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid)
        else $error("result dropped while stalled");

    // an accepted request always goes to lookup
    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == mcd_pkg::CS_LOOKUP)
        else $error("accepted request not looked up");

    // no request taken and no result shown during the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mcd_pkg::CS_CLEAR |-> o_stall && !o_valid)
        else $error("activity during clearing pass");

    // a commit follows an accept or a wait in lookup
    a_commit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> $past(o_cmd.accept) || $past(r_state) == mcd_pkg::CS_LOOKUP)
        else $error("commit without a request");
`endif

endmodule
